@@ sv/pfrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrs_pkg
// Shared types and constants for the particle field running statistics block.
// ----------------------------------------------------------------------------
package pfrs_pkg;

   localparam int FIELDS           = 6;
   localparam int DEFAULT_CHANNELS = 6;
   localparam int VALUE_W          = 32;
   localparam int SUM_W            = 48;
   localparam int SQUARE_W         = 64;
   localparam int COUNT_W          = 32;
   localparam int CHANNEL_W        = 3;
   localparam int QUEUE_DEPTH      = 4;

   localparam int REQ_DATA_W = FIELDS * VALUE_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_BITS   = 2 * VALUE_W + SUM_W + SQUARE_W + COUNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W = CHANNEL_W;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_START,
      OP_READ
   } pfrs_op_type;

   typedef struct packed {
      pfrs_op_type                         op;
      logic [FIELDS-1:0][VALUE_W-1:0]      value;
      logic [FIELDS-1:0][SQUARE_W-1:0]     square;
   } pfrs_item_type;

   localparam int ITEM_W = $bits(pfrs_item_type);

endpackage

@@ sv/pfrs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrs_queue
// Short register queue between the request front end and the update back end.
// ----------------------------------------------------------------------------
module pfrs_queue
   import pfrs_pkg::*;
#(
   parameter int WIDTH = ITEM_W,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

   a_pop_tracks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue occupancy did not drop on pop");
`endif

endmodule

@@ sv/pfrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrs_front
// Request front end: takes requests, decodes the operation and squares the
// six field values before queueing.
// ----------------------------------------------------------------------------
module pfrs_front
   import pfrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output pfrs_item_type         push_item
);

   logic                           vld_ff, vld_in;
   pfrs_op_type                    op_ff, op_in;
   logic [FIELDS-1:0][VALUE_W-1:0] val_ff;
   logic signed [SQUARE_W-1:0]     prod [FIELDS];
   logic                           load;

   assign req_tready = !vld_ff || push_ready;
   assign load       = req_tvalid && req_tready;
   assign push_valid = vld_ff;

   always_comb begin
      if (req_tuser[0]) begin
         op_in = OP_READ;
      end else if (req_tuser[1]) begin
         op_in = OP_START;
      end else begin
         op_in = OP_ADD;
      end
      if (load) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < FIELDS; i++) begin
         prod[i] = $signed(val_ff[i]) * $signed(val_ff[i]);
      end
   end

   always_comb begin
      push_item.op    = op_ff;
      push_item.value = val_ff;
      for (int i = 0; i < FIELDS; i++) begin
         push_item.square[i] = unsigned'(prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= op_in;
         val_ff <= req_tdata;
      end
   end

endmodule

@@ sv/pfrs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrs_back
// Update back end: folds records into the per-channel statistics and plays
// out one response per channel on a read.
// ----------------------------------------------------------------------------
module pfrs_back
   import pfrs_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   output logic                  head_ready,
   input  pfrs_item_type         head_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int ACTIVE = (CHANNELS < FIELDS) ? CHANNELS : FIELDS;
   localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   logic [VALUE_W-1:0]  min_ff [ACTIVE];
   logic [VALUE_W-1:0]  min_in [ACTIVE];
   logic [VALUE_W-1:0]  max_ff [ACTIVE];
   logic [VALUE_W-1:0]  max_in [ACTIVE];
   logic [SUM_W-1:0]    sum_ff [ACTIVE];
   logic [SUM_W-1:0]    sum_in [ACTIVE];
   logic [SQUARE_W-1:0] sq_ff  [ACTIVE];
   logic [SQUARE_W-1:0] sq_in  [ACTIVE];
   logic [ACTIVE-1:0]   sat_ff, sat_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                open_ff, open_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   logic                  out_vld_ff, out_vld_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_W-1:0] out_user_ff, out_user_in;
   logic                  out_last_ff, out_last_in;

   logic out_free;
   logic is_read;
   logic last_ch;
   logic emit;
   logic update;
   logic seed;
   logic count_sat;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign is_read    = (head_item.op == OP_READ);
   assign last_ch    = (idx_ff == IDX_W'(ACTIVE - 1));
   assign emit       = head_valid && is_read && out_free;
   assign update     = head_valid && !is_read;
   assign seed       = update && ((head_item.op == OP_START) || !open_ff);
   assign head_ready = !is_read || (out_free && last_ch);
   assign count_sat  = &count_ff;

   always_comb begin
      logic signed [SUM_W:0] s;
      logic [SQUARE_W:0]     q;
      logic [VALUE_W-1:0]    v;
      s = '0;
      q = '0;
      v = '0;
      count_in = count_ff;
      open_in  = open_ff;
      sat_in   = sat_ff;
      for (int c = 0; c < ACTIVE; c++) begin
         min_in[c] = min_ff[c];
         max_in[c] = max_ff[c];
         sum_in[c] = sum_ff[c];
         sq_in[c]  = sq_ff[c];
      end
      if (seed) begin
         count_in = COUNT_W'(1);
         open_in  = 1'b1;
         sat_in   = '0;
         for (int c = 0; c < ACTIVE; c++) begin
            min_in[c] = head_item.value[c];
            max_in[c] = head_item.value[c];
            sum_in[c] = SUM_W'($signed(head_item.value[c]));
            sq_in[c]  = head_item.square[c];
         end
      end else if (update) begin
         count_in = count_ff + COUNT_W'(!count_sat);
         for (int c = 0; c < ACTIVE; c++) begin
            v = head_item.value[c];
            if ($signed(v) < $signed(min_ff[c])) begin
               min_in[c] = v;
            end
            if ($signed(v) > $signed(max_ff[c])) begin
               max_in[c] = v;
            end
            s = $signed({sum_ff[c][SUM_W-1], sum_ff[c]}) + (SUM_W+1)'($signed(v));
            if (s[SUM_W] != s[SUM_W-1]) begin
               sum_in[c] = s[SUM_W] ? SUM_MIN : SUM_MAX;
               sat_in[c] = 1'b1;
            end else begin
               sum_in[c] = s[SUM_W-1:0];
            end
            q = {1'b0, sq_ff[c]} + {1'b0, head_item.square[c]};
            if (q[SQUARE_W]) begin
               sq_in[c]  = '1;
               sat_in[c] = 1'b1;
            end else begin
               sq_in[c] = q[SQUARE_W-1:0];
            end
            if (count_sat) begin
               sat_in[c] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      idx_in      = idx_ff;
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      out_user_in = out_user_ff;
      out_last_in = out_last_ff;
      if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
      if (emit) begin
         idx_in      = last_ch ? '0 : idx_ff + 1'b1;
         out_vld_in  = 1'b1;
         out_user_in = RSP_USER_W'(idx_ff);
         out_last_in = last_ch;
         out_data_in = '0;
         if (open_ff) begin
            out_data_in = RSP_DATA_W'({sat_ff[idx_ff], count_ff, sq_ff[idx_ff],
                                      sum_ff[idx_ff], max_ff[idx_ff], min_ff[idx_ff]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         open_ff    <= 1'b0;
         sat_ff     <= '0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         open_ff    <= open_in;
         sat_ff     <= sat_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < ACTIVE; c++) begin
         min_ff[c] <= min_in[c];
         max_ff[c] <= max_in[c];
         sum_ff[c] <= sum_in[c];
         sq_ff[c]  <= sq_in[c];
      end
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(ACTIVE - 1))
      else $error("readout index beyond last channel");

   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_last_ff == (out_user_ff == RSP_USER_W'(ACTIVE - 1))))
      else $error("last flag not on final channel");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      open_ff == (count_ff != '0))
      else $error("record count disagrees with open batch");

   a_read_freeze: assert property (@(posedge clock) disable iff (reset)
      (head_valid && is_read) |=> (count_ff == $past(count_ff)))
      else $error("statistics changed during readout");
`endif

endmodule

@@ sv/particle_field_running_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_field_running_stats
// Running per-field minimum, maximum, sum and sum of squares over a stream of
// six-field particle records, with a batch record count.
//
//   channel   direction  tdata                            tuser / tlast
//   req_      in         six Q16.16 fields, x lowest       command, start_batch
//   rsp_      out        min, max, total, squares, count,  channel / last
//                        saturated
//
// Accumulate requests: one per cycle while the queue has room; no response.
// Read requests: one response per channel, one per cycle while rsp_tready is
// high, from the back end's output register; the back end holds the read at the
// queue head until it emits the last channel. The first response goes through the
// front register (loaded on the edge taking the read), queue and output register.
// Synchronous reset clears control state and the record count to an empty batch.
// Either side may stall; the queue decouples front and back.
// ----------------------------------------------------------------------------
module particle_field_running_stats
   import pfrs_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // field_x, field_y, field_z, field_v1, field_w, field_v2
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command, start_batch
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // minimum, maximum, total, square_total, record_count, saturated, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // channel
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic          push_valid;
   logic          push_ready;
   pfrs_item_type push_item;
   logic          head_valid;
   logic          head_ready;
   logic [ITEM_W-1:0] head_bits;
   pfrs_item_type head_item;

   assign head_item = pfrs_item_type'(head_bits);

   pfrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   pfrs_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_item),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_bits)
   );

   pfrs_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head_item  (head_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
